// File: rtl/ukl_pkg.sv
// ----------------------------------------------------------------------------
// ukl_pkg
// Shared types and constants for the unique key list engine: request and
// result codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package ukl_pkg;

	// field widths
	localparam int OP_W       = 2;
	localparam int KEY_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int POS_W      = 4;
	localparam int FILL_W     = 5;
	localparam int LIMIT_W    = 5;

	// stream widths (tdata padded to whole bytes)
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_USER_W = 3;
	localparam int OUT_PAD_W  = OUT_DATA_W - POS_W - FILL_W;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	// request codes
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2
	} ukl_op_t;

	// result codes
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 3'd0,
		ST_DUP   = 3'd1,
		ST_OVER  = 3'd2,
		ST_MISS  = 3'd3,
		ST_UNDER = 3'd4
	} ukl_status_t;

	// source of the reported position
	typedef enum logic [1:0] {
		POS_ZERO,
		POS_IDX,
		POS_FILL
	} ukl_pos_sel_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_CMP,
		S_SHIFT,
		S_MOVE,
		S_FINISH
	} ukl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic         load_req;
		logic         idx_inc;
		logic         rd_en;
		logic         rd_next;
		logic         wr_append;
		logic         wr_move;
		logic         fill_inc;
		logic         fill_dec;
		logic         res_we;
		ukl_status_t  res_status;
		ukl_pos_sel_t res_pos_sel;
		logic         out_load;
	} ukl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            empty;
		logic            at_end;
		logic            at_last;
		logic            hit;
		logic            out_free;
	} ukl_sts_t;

endpackage

// File: rtl/ukl_ctrl.sv
// ----------------------------------------------------------------------------
// ukl_ctrl
// Sequencer for the key list: checks limits, walks the list one entry per
// compare, appends on insert and closes the gap on remove.
// ----------------------------------------------------------------------------
module ukl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              in_ready,
	input  ukl_pkg::ukl_sts_t sts,
	output ukl_pkg::ukl_cmd_t cmd
);
	import ukl_pkg::*;

	ukl_state_t state_q;
	ukl_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt           = state_q;
		cmd                 = '0;
		cmd.res_status      = ST_DONE;
		cmd.res_pos_sel     = POS_ZERO;
		in_ready            = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					state_nxt    = S_CHECK;
				end
			end
			// limit checks before any scan
			S_CHECK: begin
				case (sts.op)
					OP_INSERT: begin
						if (sts.full) begin
							cmd.res_we     = 1'b1;
							cmd.res_status = ST_OVER;
							state_nxt      = S_FINISH;
						end else begin
							state_nxt = S_SCAN;
						end
					end
					OP_REMOVE: begin
						if (sts.empty) begin
							cmd.res_we     = 1'b1;
							cmd.res_status = ST_UNDER;
							state_nxt      = S_FINISH;
						end else begin
							state_nxt = S_SCAN;
						end
					end
					OP_SEARCH: begin
						state_nxt = S_SCAN;
					end
					default: begin
						// unused code: no change, reported as not found
						cmd.res_we     = 1'b1;
						cmd.res_status = ST_MISS;
						state_nxt      = S_FINISH;
					end
				endcase
			end
			// read next filled entry, or end of list reached
			S_SCAN: begin
				if (sts.at_end) begin
					cmd.res_we = 1'b1;
					if (sts.op == OP_INSERT) begin
						cmd.wr_append   = 1'b1;
						cmd.fill_inc    = 1'b1;
						cmd.res_status  = ST_DONE;
						cmd.res_pos_sel = POS_FILL;
					end else begin
						cmd.res_status = ST_MISS;
					end
					state_nxt = S_FINISH;
				end else begin
					cmd.rd_en = 1'b1;
					state_nxt = S_CMP;
				end
			end
			// compare registered entry with the key
			S_CMP: begin
				if (sts.hit) begin
					cmd.res_we      = 1'b1;
					cmd.res_pos_sel = POS_IDX;
					case (sts.op)
						OP_INSERT: begin
							cmd.res_status = ST_DUP;
							state_nxt      = S_FINISH;
						end
						OP_REMOVE: begin
							cmd.res_status = ST_DONE;
							state_nxt      = S_SHIFT;
						end
						default: begin
							cmd.res_status = ST_DONE;
							state_nxt      = S_FINISH;
						end
					endcase
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = S_SCAN;
				end
			end
			// close the gap one entry at a time
			S_SHIFT: begin
				if (sts.at_last) begin
					cmd.fill_dec = 1'b1;
					state_nxt    = S_FINISH;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_next = 1'b1;
					state_nxt   = S_MOVE;
				end
			end
			S_MOVE: begin
				cmd.wr_move = 1'b1;
				cmd.idx_inc = 1'b1;
				state_nxt   = S_SHIFT;
			end
			// hand result to the output register once it is free
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/ukl_datapath.sv
// ----------------------------------------------------------------------------
// ukl_datapath
// Key memory, fill count, scan index, limit register, result registers and
// the output register of the key list engine.
// ----------------------------------------------------------------------------
module ukl_datapath #(
	parameter int CAPACITY = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ukl_pkg::ukl_cmd_t               cmd,
	output ukl_pkg::ukl_sts_t               sts,
	input  logic [ukl_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [ukl_pkg::IN_USER_W-1:0]   s_tuser,
	input  logic                            cfg_valid,
	input  logic [ukl_pkg::LIMIT_W-1:0]     cfg_data,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ukl_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [ukl_pkg::OUT_USER_W-1:0]  m_tuser
);
	import ukl_pkg::*;

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

	logic [KEY_W-1:0]    mem [CAPACITY];

	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       filled_q;
	logic [LIMIT_W-1:0]  list_size_q;
	logic [KEY_W-1:0]    rd_data_q;
	ukl_status_t         status_q;
	logic [AW-1:0]       pos_q;
	logic                out_valid_q;

	logic [CW-1:0]       idx_nxt;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [KEY_W-1:0]    wr_data;
	logic                wr_en;
	logic [CMPW-1:0]     filled_ext;
	logic [CMPW-1:0]     size_ext;
	logic [CMPW-1:0]     limit;
	logic [AW-1:0]       pos_nxt;

	// address and limit logic
	always_comb begin
		idx_nxt    = idx_q + CW'(1);
		rd_addr    = cmd.rd_next ? idx_nxt[AW-1:0] : idx_q[AW-1:0];
		wr_en      = cmd.wr_append | cmd.wr_move;
		wr_addr    = cmd.wr_append ? filled_q[AW-1:0] : idx_q[AW-1:0];
		wr_data    = cmd.wr_append ? key_q : rd_data_q;
		filled_ext = CMPW'(filled_q);
		size_ext   = CMPW'(list_size_q);
		limit      = (size_ext > CMPW'(CAPACITY)) ? CMPW'(CAPACITY) : size_ext;
		case (cmd.res_pos_sel)
			POS_IDX:  pos_nxt = idx_q[AW-1:0];
			POS_FILL: pos_nxt = filled_q[AW-1:0];
			default:  pos_nxt = '0;
		endcase
	end

	// status to controller
	always_comb begin
		sts.op       = op_q;
		sts.full     = filled_ext >= limit;
		sts.empty    = filled_q == '0;
		sts.at_end   = idx_q == filled_q;
		sts.at_last  = idx_nxt == filled_q;
		sts.hit      = rd_data_q == key_q;
		sts.out_free = !out_valid_q || m_tready;
	end

	// key memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// request, index and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q  <= s_tuser[OP_W-1:0];
			key_q <= s_tdata[KEY_W-1:0];
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_nxt;
		end
		if (cmd.res_we) begin
			status_q <= cmd.res_status;
			pos_q    <= pos_nxt;
		end
	end

	// fill count and limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q    <= '0;
			list_size_q <= LIMIT_RESET;
		end else begin
			if (cmd.fill_inc) begin
				filled_q <= filled_q + CW'(1);
			end else if (cmd.fill_dec) begin
				filled_q <= filled_q - CW'(1);
			end
			if (cfg_valid) begin
				list_size_q <= cfg_data;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tuser <= status_q;
			m_tdata <= {{OUT_PAD_W{1'b0}}, FILL_W'(filled_q), POS_W'(pos_q)};
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// File: rtl/unique_key_list_engine_unit.sv
// Flow: S_CHECK tests the limits, then S_SCAN and S_CMP alternate per entry until a
//   hit or the end of the list; overflow, underflow and unused op go to S_FINISH.
// A remove that hits then moves each later entry down one place via S_SHIFT/S_MOVE.
// Throughput: one request at a time, the next taken the cycle after the result is
//   loaded; a held output register stalls the finish step until it drains.
// Reset: arst_n clears fill count and output valid, sets list_size to 16.
// ----------------------------------------------------------------------------
// unique_key_list_engine_unit
// Compact list of distinct 32-bit keys with insert, remove and search
// requests; each request returns status, position and fill count.
// ----------------------------------------------------------------------------
module unique_key_list_engine_unit #(
	parameter int CAPACITY = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ukl_pkg::IN_DATA_W-1:0]   s_tdata,   // [31:0] key
	input  logic [ukl_pkg::IN_USER_W-1:0]   s_tuser,   // [1:0] operation
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ukl_pkg::OUT_DATA_W-1:0]  m_tdata,   // [3:0] position, [8:4] fill_count
	output logic [ukl_pkg::OUT_USER_W-1:0]  m_tuser,   // [2:0] status
	// list_size register write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ukl_pkg::LIMIT_W-1:0]     cfg_data
);
	import ukl_pkg::*;

	ukl_cmd_t cmd;
	ukl_sts_t sts;

	// register writes are taken at any time
	assign cfg_ready = 1'b1;

	ukl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ukl_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
